@@ rtl/rrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrf_pkg: shared types and constants of the record ring FIFO
// Item layouts, operation and result codes, and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrf_pkg;

  // Default geometry of the ring
  localparam int CAPACITY_DEFAULT         = 16;
  localparam int MAX_RECORD_BYTES_DEFAULT = 64;

  // Field widths fixed by the item layouts
  localparam int BYTE_BITS = 8;
  localparam int OCC_W     = 5;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_t;

  typedef struct packed {
    func_t                 func;
    logic [BYTE_BITS-1:0]  data_byte;
    logic                  last;
  } cmd_item_t;

  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic [BYTE_BITS-1:0]  out_byte;
    logic                  end_of_run;
    logic [OCC_W-1:0]      occupancy;
    logic                  is_full;
    logic                  is_empty;
  } rsp_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic push;       // accepted push word
    logic pop_start;  // accepted pop of a stored record
    logic pop_empty;  // accepted pop of an empty ring
    logic load_byte;  // move the RAM read word into the result register
    logic read_next;  // read the following byte of the record
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;      // no record stored
    logic out_free;   // result register can take a word this cycle
    logic rd_last;    // RAM read word is the final byte of its record
  } dp_sts_t;

endpackage

@@ rtl/rrf_if.sv @@
// ----------------------------------------------------------------------------
// rrf_if: handshake channels of the record ring FIFO
// Valid/ready channels carrying one command word or one result word.
// ----------------------------------------------------------------------------
interface rrf_cmd_if import rrf_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface rrf_rsp_if import rrf_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/rrf_ram.sv @@
// ----------------------------------------------------------------------------
// rrf_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module rrf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold the last word while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrf_ctrl: controller of the record ring FIFO
// Accepts command words and sequences the byte stream of a pop.
// ----------------------------------------------------------------------------
module rrf_ctrl import rrf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  func_t    in_func,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmds
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmds       = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_func == FUNC_PUSH) begin
            cmds.push = 1'b1;
          end else if (sts.empty) begin
            cmds.pop_empty = 1'b1;
          end else begin
            cmds.pop_start = 1'b1;
            state_next     = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        // Emit one byte per free result slot, stop at the final byte
        if (sts.out_free) begin
          cmds.load_byte = 1'b1;
          if (sts.rd_last) begin
            state_next = ST_IDLE;
          end else begin
            cmds.read_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rrf_dp.sv @@
// ----------------------------------------------------------------------------
// rrf_dp: datapath of the record ring FIFO
// Ring pointers, record assembly, record RAM and the result register.
// ----------------------------------------------------------------------------
module rrf_dp import rrf_pkg::*; #(
  parameter int CAPACITY         = CAPACITY_DEFAULT,
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_item_t in_item,
  input  ctl_cmd_t  cmds,
  output dp_sts_t   sts,
  output logic      out_valid,
  output rsp_item_t out_item,
  input  logic      out_ready
);

  // One spare slot holds the record in assembly, so assembly never writes into a stored record, even with a full ring
  localparam int PSLOTS  = CAPACITY + 1;
  localparam int PSLOT_W = $clog2(PSLOTS);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int BYTE_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int BC_W    = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES + 1) : 1;
  localparam int ADDR_W  = PSLOT_W + BYTE_W;
  localparam int DEPTH   = PSLOTS * (2 ** BYTE_W);
  localparam int WORD_W  = BYTE_BITS + 1;

  logic [PSLOT_W-1:0] wslot, rslot, rd_slot;
  logic [COUNT_W-1:0] count, count_after;
  logic [BC_W-1:0]    bytes_collected;
  logic               too_long;
  logic [BYTE_W-1:0]  rd_idx;

  logic               room, full, commit, commit_ok, too_long_eff, load;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;
  status_t            push_status;

  // Assembly and commit decisions
  assign room         = bytes_collected < BC_W'(MAX_RECORD_BYTES);
  assign full         = count == COUNT_W'(CAPACITY);
  assign commit       = cmds.push && in_item.last;
  assign too_long_eff = too_long || !room;
  assign commit_ok    = commit && !too_long_eff && !full;
  assign count_after  = commit_ok ? count + COUNT_W'(1) : count;

  always_comb begin
    if (too_long_eff) begin
      push_status = STATUS_TOO_LONG;
    end else if (full) begin
      push_status = STATUS_FULL;
    end else begin
      push_status = STATUS_OK;
    end
  end

  // Record RAM: each word carries the byte and its end-of-record mark
  assign ram_we    = cmds.push && room;
  assign ram_waddr = {wslot, bytes_collected[BYTE_W-1:0]};
  assign ram_wdata = {in_item.last, in_item.data_byte};
  assign ram_re    = cmds.pop_start || cmds.read_next;
  assign ram_raddr = cmds.pop_start ? {rslot, BYTE_W'(0)} : {rd_slot, rd_idx};

  rrf_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_record_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ring pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wslot <= '0;
      rslot <= '0;
      count <= '0;
    end else begin
      if (commit_ok) begin
        wslot <= (wslot == PSLOT_W'(CAPACITY)) ? '0 : wslot + PSLOT_W'(1);
        count <= count + COUNT_W'(1);
      end else if (cmds.pop_start) begin
        rslot <= (rslot == PSLOT_W'(CAPACITY)) ? '0 : rslot + PSLOT_W'(1);
        count <= count - COUNT_W'(1);
      end
    end
  end

  // Record assembly: count bytes, flag overflow, restart at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_collected <= '0;
      too_long        <= 1'b0;
    end else if (commit) begin
      bytes_collected <= '0;
      too_long        <= 1'b0;
    end else if (cmds.push) begin
      if (room) begin
        bytes_collected <= bytes_collected + BC_W'(1);
      end else begin
        too_long <= 1'b1;
      end
    end
  end

  // Pop read address: slot latched at start, advance byte index per read
  always_ff @(posedge clk) begin
    if (cmds.pop_start) begin
      rd_slot <= rslot;
      rd_idx  <= BYTE_W'(1);
    end else if (cmds.read_next) begin
      rd_idx <= rd_idx + BYTE_W'(1);
    end
  end

  // Result register
  assign load = commit || cmds.pop_empty || cmds.load_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.occupancy <= OCC_W'(count_after);
      out_item.is_full   <= count_after == COUNT_W'(CAPACITY);
      out_item.is_empty  <= count_after == '0;
      if (cmds.load_byte) begin
        out_item.kind       <= KIND_BYTE;
        out_item.status     <= STATUS_OK;
        out_item.out_byte   <= ram_rdata[BYTE_BITS-1:0];
        out_item.end_of_run <= ram_rdata[BYTE_BITS];
      end else if (cmds.pop_empty) begin
        out_item.kind       <= KIND_EMPTY;
        out_item.status     <= STATUS_OK;
        out_item.out_byte   <= '0;
        out_item.end_of_run <= 1'b1;
      end else begin
        out_item.kind       <= KIND_PUSH;
        out_item.status     <= push_status;
        out_item.out_byte   <= '0;
        out_item.end_of_run <= 1'b1;
      end
    end
  end

  // Status to the controller
  assign sts.empty    = count == '0;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.rd_last  = ram_rdata[BYTE_BITS];

endmodule

@@ rtl/record_ring_fifo.sv @@
// ----------------------------------------------------------------------------
// record_ring_fifo: FIFO of variable-length byte records in a slot ring
//
//   Channel  Role    Word
//   cmd      sink    func, data_byte, last (push one byte or pop a record)
//   rsp      source  kind, status, out_byte, end_of_run, occupancy, flags
//
// Every cmd word, push or pop, waits for a free result register, since the
// final byte of a record loads its status word. A pop of an empty ring loads
// its result word as it is taken. A pop of a record reads its first byte
// from the record RAM, then streams one byte per cycle while the result
// register is free, through the single registered read port. One item is
// in work at a time. Reset clears pointers, occupancy and assembly state;
// the record RAM is not cleared. A stalled rsp holds the result register
// and the byte stream.
// ----------------------------------------------------------------------------
module record_ring_fifo import rrf_pkg::*; #(
  parameter int CAPACITY         = CAPACITY_DEFAULT,
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  rrf_cmd_if.sink     cmd,
  rrf_rsp_if.source   rsp
);

  ctl_cmd_t  cmds;
  dp_sts_t   sts;
  logic      out_valid;
  rsp_item_t out_item;

  rrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_func  (cmd.item.func),
    .in_ready (cmd.ready),
    .sts      (sts),
    .cmds     (cmds)
  );

  rrf_dp #(
    .CAPACITY         (CAPACITY),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (cmd.item),
    .cmds      (cmds),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (rsp.ready)
  );

  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

  // No new word is taken while a record streams out
  a_no_accept_in_stream: assert property (@(posedge clk) disable iff (rst)
    cmds.load_byte |-> !(cmd.valid && cmd.ready))
    else $error("command accepted during pop stream");

  // A pop of a stored record blocks the command side on the next cycle
  a_pop_blocks: assert property (@(posedge clk) disable iff (rst)
    cmds.pop_start |=> !cmd.ready)
    else $error("command side open right after pop start");

  // Results are loaded only into a free result register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmds.load_byte || cmds.pop_empty || (cmds.push && cmd.item.last))
      |-> sts.out_free)
    else $error("result loaded over a waiting word");

  // Full and empty never both flagged
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.item.is_full && rsp.item.is_empty))
    else $error("full and empty flagged together");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the record ring FIFO
// Drives push and pop words through the cmd channel in random bursts, stalls
// the rsp channel on a rolling pattern, and checks every result word against
// an in-order model of the ring: record slots, lengths, pointers and the
// record in assembly. Covers empty pops, full and too-long drops, records of
// the maximum length, and pops issued while a record is still being built.
// ----------------------------------------------------------------------------
import rrf_pkg::*;

class record_ring_predictor #(int SLOTS = 16, int MAX_BYTES = 64);
  logic [7:0] slot_data [SLOTS][MAX_BYTES];
  int         slot_len  [SLOTS];
  logic [7:0] assembly  [MAX_BYTES];
  int         wr_ptr;
  int         rd_ptr;
  int         collected;
  bit         overlong;
  rsp_item_t  expected_words [$];
  int         mismatches;

  function int records_held();
    return (wr_ptr - rd_ptr) & (2 * SLOTS - 1);
  endfunction

  // Queue one result word, flags taken from the ring after the step
  function void queue_word(kind_t k, status_t s, logic [7:0] b, logic eor);
    rsp_item_t w;
    int        n;
    n            = records_held();
    w.kind       = k;
    w.status     = s;
    w.out_byte   = b;
    w.end_of_run = eor;
    w.occupancy  = OCC_W'(n);
    w.is_full    = (n >= SLOTS);
    w.is_empty   = (n == 0);
    expected_words.push_back(w);
  endfunction

  // Advance the ring by one accepted cmd word
  function void note_cmd(cmd_item_t w);
    int      slot;
    int      i;
    status_t s;
    if (w.func == FUNC_PUSH) begin
      if (collected < MAX_BYTES) begin
        assembly[collected] = w.data_byte;
        collected++;
      end else begin
        overlong = 1'b1;
      end
      if (!w.last) return;
      // too long wins over full
      if (overlong) begin
        s = STATUS_TOO_LONG;
      end else if (records_held() >= SLOTS) begin
        s = STATUS_FULL;
      end else begin
        slot = wr_ptr % SLOTS;
        for (i = 0; i < collected; i++) slot_data[slot][i] = assembly[i];
        slot_len[slot] = collected;
        wr_ptr         = (wr_ptr + 1) % (2 * SLOTS);
        s              = STATUS_OK;
      end
      collected = 0;
      overlong  = 1'b0;
      queue_word(KIND_PUSH, s, 8'h00, 1'b1);
    end else if (records_held() == 0) begin
      queue_word(KIND_EMPTY, STATUS_OK, 8'h00, 1'b1);
    end else begin
      slot   = rd_ptr % SLOTS;
      rd_ptr = (rd_ptr + 1) % (2 * SLOTS);
      for (i = 0; i < slot_len[slot]; i++) begin
        queue_word(KIND_BYTE, STATUS_OK, slot_data[slot][i], i == slot_len[slot] - 1);
      end
    end
  endfunction

  function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Match one accepted result word against the oldest expectation
  function void check_rsp(rsp_item_t got);
    rsp_item_t want;
    if (expected_words.size() == 0) begin
      $error("result word with none expected: kind %0d, out_byte %0d",
             got.kind, got.out_byte);
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("status", want.status, got.status);
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("end_of_run", want.end_of_run, got.end_of_run);
    compare_field("occupancy", want.occupancy, got.occupancy);
    compare_field("is_full", want.is_full, got.is_full);
    compare_field("is_empty", want.is_empty, got.is_empty);
  endfunction
endclass

module testbench;

  localparam int SLOTS       = CAPACITY_DEFAULT;
  localparam int MAX_BYTES   = MAX_RECORD_BYTES_DEFAULT;
  localparam int RANDOM_WORDS = 296;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;

  rrf_cmd_if cmd ();
  rrf_rsp_if rsp ();

  record_ring_fifo #(
    .CAPACITY         (SLOTS),
    .MAX_RECORD_BYTES (MAX_BYTES)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  record_ring_predictor #(SLOTS, MAX_BYTES) ring_model;

  int          burst_left;
  int          words_sent;
  int          quiet_cycles;
  logic [15:0] stall_mask;
  logic [5:0]  stall_phase;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall rsp on a rolling pattern from a 16-bit mask, rerolled each time the 6-bit phase wraps
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready   <= 1'b0;
      stall_mask  <= '0;
      stall_phase <= '0;
    end else begin
      if (stall_phase == 6'd0) begin
        if ($urandom_range(0, 3) == 0) stall_mask <= '0;
        else stall_mask <= 16'($urandom_range(0, 16'hFFFF)) & 16'hFFFE;
      end
      rsp.ready   <= !stall_mask[stall_phase[3:0]];
      stall_phase <= stall_phase + 6'd1;
    end
  end

  // Observe handshakes at the falling edge, ahead of the rising edge that takes them
  always @(negedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready) ring_model.note_cmd(cmd.item);
      if (rsp.valid && rsp.ready) ring_model.check_rsp(rsp.item);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("record_ring_fifo regression: fail");
        $finish;
      end
    end
  end

  // Send one cmd word, opening a new burst after a random gap when due
  task automatic send_word(func_t f, logic [7:0] b, logic l);
    cmd_item_t w;
    int        gap;
    w.func      = f;
    w.data_byte = b;
    w.last      = l;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.item  <= w;
    do @(negedge clk); while (!cmd.ready);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic send_pop();
    send_word(FUNC_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Push a record of len bytes, optionally slipping pops into the assembly
  task automatic send_record(int len, bit mix_pops);
    int i;
    for (i = 0; i < len; i++) begin
      if (mix_pops && $urandom_range(0, 19) == 0) send_pop();
      send_word(FUNC_PUSH, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, 6);
    if (r < 94) return $urandom_range(7, 40);
    if (r < 97) return MAX_BYTES;
    return $urandom_range(MAX_BYTES + 1, MAX_BYTES + 2);
  endfunction

  initial begin
    int  i;
    int  target;
    int  actions;
    bit  fill_mode;
    ring_model   = new;
    rst          = 1'b1;
    cmd.valid    = 1'b0;
    cmd.item     = '0;
    burst_left   = 0;
    words_sent   = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme bytes, empty pop, pop during assembly
    send_word(FUNC_PUSH, 8'h00, 1'b1);
    send_word(FUNC_PUSH, 8'hFF, 1'b1);
    send_word(FUNC_POP, 8'hFF, 1'b1);
    send_word(FUNC_POP, 8'h00, 1'b0);
    send_word(FUNC_POP, 8'h00, 1'b0);
    send_word(FUNC_PUSH, 8'hA5, 1'b0);
    send_word(FUNC_POP, 8'h5A, 1'b1);
    send_word(FUNC_PUSH, 8'h5A, 1'b1);
    send_word(FUNC_POP, 8'h00, 1'b0);
    send_word(FUNC_POP, 8'h00, 1'b0);

    // fill the ring, overflow it, then an overlong record against the full ring
    for (i = 0; i <= SLOTS; i++) send_record(1, 1'b0);
    send_record(MAX_BYTES + 1, 1'b0);
    for (i = 0; i <= SLOTS; i++) send_pop();

    // record of exactly the maximum length
    send_record(MAX_BYTES, 1'b0);
    send_pop();

    // random records and pops, alternating fill and drain phases
    target    = words_sent + RANDOM_WORDS;
    actions   = 0;
    fill_mode = 1'b1;
    while (words_sent < target) begin
      if (actions % 24 == 23) fill_mode = !fill_mode;
      actions++;
      if ($urandom_range(0, 99) < (fill_mode ? 75 : 30)) send_record(pick_length(), 1'b1);
      else send_pop();
    end
    cmd.valid <= 1'b0;

    while (ring_model.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ring_model.mismatches == 0) begin
      $display("record_ring_fifo regression: pass");
    end else begin
      $display("record_ring_fifo regression: fail");
    end
    $finish;
  end

endmodule

@@ record_ring_fifo.f @@
rtl/rrf_pkg.sv
rtl/rrf_if.sv
rtl/rrf_ram.sv
rtl/rrf_ctrl.sv
rtl/rrf_dp.sv
rtl/record_ring_fifo.sv
test/testbench.sv
